// ----- rtl/core/medf_pkg.sv -----
// shared types and constants of the 3x3 median image filter
// payload structs, register indexes, opcodes and default sizes
// no dependencies
package medf_pkg;

  // default sizes, handed down through top level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 16;

  // fixed field widths of the ports
  localparam int PIX_W      = 16;
  localparam int FW_BITS    = 11;
  localparam int FH_BITS    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // register reset values
  localparam int FW_RESET = 640;
  localparam int FH_RESET = 480;

  // window columns and output queue size
  localparam int WIN_COLS  = 3;
  localparam int OUT_DEPTH = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } result_t;

endpackage

// ----- rtl/core/median_3x3_image_filter.sv -----
// 3x3 median image filter, top level; needs medf_pkg, medf_ram, medf_col_cell, medf_out_fifo
// throughput: one item per clock while item_stall is low; each item does one read per
//   line store, each pixel item one window shift; results enter the queue through the
//   pipeline stage registers; in the stream, outputs trail pixel inputs by width+1 pixels
// reset (rst, synchronous): clears positions, pending count, pipeline and result queue and
//   loads 640 x 480; line stores and window hold old data, no clearing pass is run
module median_3x3_image_filter #(
  parameter int MAX_WIDTH  = medf_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = medf_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  medf_pkg::item_t                   item,
  // output channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output medf_pkg::result_t                 result,
  // register write port
  input  logic                              cfg_write,
  input  logic [medf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [medf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import medf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH + 1);   // effective width 1..MAX_WIDTH
  localparam int AW    = $clog2(MAX_WIDTH);       // column / line store address
  localparam int PW    = $clog2(MAX_WIDTH + 2);   // pending count 0..width+1
  localparam int SW    = PW + 2;                  // signed history offset math
  localparam int PB    = PIXEL_BITS;
  localparam int W_RST = (FW_RESET > MAX_WIDTH) ? MAX_WIDTH : FW_RESET;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int INF_W = $clog2(OUT_DEPTH + 4);

  function automatic logic [PB-1:0] med3(input logic [PB-1:0] a, input logic [PB-1:0] b,
                                         input logic [PB-1:0] c);
    logic [PB-1:0] lo;
    logic [PB-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) begin
      return hi;
    end else if (c <= lo) begin
      return lo;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // frame geometry, derived when written
  // --------------------------------------------------------------------------
  logic [CW-1:0]      w_eff;
  logic [AW-1:0]      wm1;
  logic [PW-1:0]      wp1;
  logic [FH_BITS-1:0] hm1;

  logic [FW_BITS-1:0] fw_wr;
  logic [CW-1:0]      w_wr;
  logic [FH_BITS-1:0] fh_wr;

  assign fw_wr = cfg_data[FW_BITS-1:0];
  assign fh_wr = cfg_data[FH_BITS-1:0];

  // zero width acts as one, oversize width clamps to the line store depth
  always_comb begin
    if (fw_wr == '0) begin
      w_wr = CW'(1);
    end else if (32'(fw_wr) > 32'(MAX_WIDTH)) begin
      w_wr = CW'(MAX_WIDTH);
    end else begin
      w_wr = CW'(fw_wr);
    end
  end

  // --------------------------------------------------------------------------
  // stream position state
  // --------------------------------------------------------------------------
  logic [AW-1:0]      in_col;
  logic [FH_BITS-1:0] in_row;
  logic [AW-1:0]      out_col;
  logic [FH_BITS-1:0] out_row;
  logic [PW-1:0]      pending;

  logic [AW-1:0]      in_col_next;
  logic [FH_BITS-1:0] in_row_next;
  logic [AW-1:0]      out_col_next;
  logic [FH_BITS-1:0] out_row_next;

  logic accept;
  logic is_drain;
  logic pix_acc;
  logic emit_now;
  logic inner_now;
  logic fend_now;

  logic [PB-1:0] pix_masked;

  // history lookup of the oldest pending pixel for drain beats
  logic signed [SW-1:0] t_a;
  logic signed [SW-1:0] t_b;
  logic [AW-1:0]        drn_addr;
  logic                 drn_up;
  logic [AW-1:0]        rd_addr;
  logic                 byp_now;

  assign accept     = item_valid && !item_stall;
  assign is_drain   = (item.op == OP_DRAIN);
  assign pix_acc    = accept && !is_drain;
  assign pix_masked = item.pixel_in[PB-1:0];

  // pixel beats emit once width+1 pixels are pending, drains whenever any are
  assign emit_now = is_drain ? (pending != '0) : (pending >= wp1);

  // border rows and columns pass the original pixel, drain beats always do
  assign inner_now = !is_drain && (out_row != '0) && (out_row < hm1) &&
                     (out_col != '0) && (out_col < wm1);
  assign fend_now  = (out_row == hm1) && (out_col == wm1);

  // oldest pending pixel is "pending" pixels back in raster order: current row lives in
  // the middle store left of in_col, the previous row in middle right of it and in upper
  // left of it, the row before that only at the last column of upper
  always_comb begin
    t_a = $signed(SW'(in_col)) - $signed(SW'(pending));
    t_b = t_a + $signed(SW'(w_eff));
    if (!t_a[SW-1]) begin
      drn_up   = 1'b0;
      drn_addr = t_a[AW-1:0];
    end else if (t_b[SW-1]) begin
      drn_up   = 1'b1;
      drn_addr = wm1;
    end else if (t_b >= $signed(SW'(in_col))) begin
      drn_up   = 1'b0;
      drn_addr = t_b[AW-1:0];
    end else begin
      drn_up   = 1'b1;
      drn_addr = t_b[AW-1:0];
    end
  end

  assign rd_addr = is_drain ? drn_addr : in_col;

  always_comb begin
    if (in_col >= wm1) begin
      in_col_next = '0;
      in_row_next = (in_row >= hm1) ? '0 : in_row + 1'b1;
    end else begin
      in_col_next = in_col + 1'b1;
      in_row_next = in_row;
    end
    if (out_col >= wm1) begin
      out_col_next = '0;
      out_row_next = (out_row >= hm1) ? '0 : out_row + 1'b1;
    end else begin
      out_col_next = out_col + 1'b1;
      out_row_next = out_row;
    end
  end

  // any register write restarts the stream, the line stores keep their data
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff   <= CW'(W_RST);
      wm1     <= AW'(W_RST - 1);
      wp1     <= PW'(W_RST + 1);
      hm1     <= FH_BITS'(FH_RESET - 1);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          w_eff <= w_wr;
          wm1   <= AW'(w_wr - 1'b1);
          wp1   <= PW'(w_wr) + 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          hm1 <= (fh_wr == '0) ? '0 : fh_wr - 1'b1;
        end
        default: begin
        end
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
    end else if (accept) begin
      if (!is_drain) begin
        in_col <= in_col_next;
        in_row <= in_row_next;
      end
      if (emit_now) begin
        out_col <= out_col_next;
        out_row <= out_row_next;
      end
      if (is_drain && emit_now) begin
        pending <= pending - 1'b1;
      end else if (!is_drain && !emit_now) begin
        pending <= pending + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // line stores: middle written at pixel accept, upper gets the displaced middle
  // pixel in the next cycle from the middle read data
  // --------------------------------------------------------------------------
  logic [PB-1:0] up_rd;
  logic [PB-1:0] mid_rd;

  // stage 1 registers
  logic          p1_pix_item;
  logic          p1_emit;
  logic          p1_inner;
  logic          p1_fend;
  logic          p1_up_sel;
  logic          p1_byp;
  logic [PB-1:0] p1_byp_data;
  logic [PB-1:0] p1_pix;
  logic [AW-1:0] p1_col;

  // an upper read at the address being written back this cycle takes the new data
  assign byp_now = p1_pix_item && (p1_col == rd_addr);

  medf_ram #(
    .WIDTH (PB),
    .DEPTH (MAX_WIDTH)
  ) u_mid_store (
    .clk   (clk),
    .we    (pix_acc),
    .waddr (in_col),
    .wdata (pix_masked),
    .raddr (rd_addr),
    .rdata (mid_rd)
  );

  medf_ram #(
    .WIDTH (PB),
    .DEPTH (MAX_WIDTH)
  ) u_up_store (
    .clk   (clk),
    .we    (p1_pix_item),
    .waddr (p1_col),
    .wdata (mid_rd),
    .raddr (rd_addr),
    .rdata (up_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_pix_item <= 1'b0;
      p1_emit     <= 1'b0;
    end else begin
      p1_pix_item <= pix_acc;
      p1_emit     <= accept && emit_now;
    end
  end

  always_ff @(posedge clk) begin
    p1_inner    <= inner_now;
    p1_fend     <= fend_now;
    p1_up_sel   <= drn_up;
    p1_byp      <= byp_now;
    p1_byp_data <= mid_rd;
    p1_pix      <= pix_masked;
    p1_col      <= in_col;
  end

  // --------------------------------------------------------------------------
  // stage 1: sort the incoming column and shift it into the cell chain
  // --------------------------------------------------------------------------
  logic [PB-1:0] up_eff;
  logic [PB-1:0] hd_lo;
  logic [PB-1:0] hd_md;
  logic [PB-1:0] hd_hi;
  logic [PB-1:0] raw1;

  wire [PB-1:0] cl_lo  [WIN_COLS+1];
  wire [PB-1:0] cl_md  [WIN_COLS+1];
  wire [PB-1:0] cl_hi  [WIN_COLS+1];
  wire [PB-1:0] cl_ctr [WIN_COLS+1];
  wire [PB-1:0] acc_lo [WIN_COLS+1];
  wire [PB-1:0] acc_hi [WIN_COLS+1];

  assign up_eff = p1_byp ? p1_byp_data : up_rd;

  // three compare-exchanges: upper, middle and new row of the column
  always_comb begin
    logic [PB-1:0] x0;
    logic [PB-1:0] x1;
    logic [PB-1:0] y1;
    x0    = (up_eff < mid_rd) ? up_eff : mid_rd;
    x1    = (up_eff < mid_rd) ? mid_rd : up_eff;
    y1    = (x1 < p1_pix) ? x1 : p1_pix;
    hd_hi = (x1 < p1_pix) ? p1_pix : x1;
    hd_lo = (x0 < y1) ? x0 : y1;
    hd_md = (x0 < y1) ? y1 : x0;
  end

  assign cl_lo[0]  = hd_lo;
  assign cl_md[0]  = hd_md;
  assign cl_hi[0]  = hd_hi;
  assign cl_ctr[0] = mid_rd;
  assign acc_lo[0] = '0;
  assign acc_hi[0] = '1;

  // cell 0 holds the newest column, the last cell the oldest
  for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
    medf_col_cell #(
      .PIX_BITS (PB)
    ) u_cell (
      .clk       (clk),
      .shift     (p1_pix_item),
      .lo_in     (cl_lo[i]),
      .md_in     (cl_md[i]),
      .hi_in     (cl_hi[i]),
      .ctr_in    (cl_ctr[i]),
      .lo_acc_in (acc_lo[i]),
      .hi_acc_in (acc_hi[i]),
      .lo        (cl_lo[i+1]),
      .md        (cl_md[i+1]),
      .hi        (cl_hi[i+1]),
      .ctr       (cl_ctr[i+1]),
      .lo_acc    (acc_lo[i+1]),
      .hi_acc    (acc_hi[i+1])
    );
  end

  // unfiltered value: for a pixel beat the window center after this shift, which is
  // the center pixel of the newest cell before it; for a drain beat the store read
  assign raw1 = p1_pix_item ? cl_ctr[1] : (p1_up_sel ? up_eff : mid_rd);

  // stage 2 registers
  logic          p2_emit;
  logic          p2_inner;
  logic          p2_fend;
  logic [PB-1:0] p2_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_emit <= 1'b0;
    end else begin
      p2_emit <= p1_emit;
    end
  end

  always_ff @(posedge clk) begin
    p2_inner <= p1_inner;
    p2_fend  <= p1_fend;
    p2_raw   <= raw1;
  end

  // --------------------------------------------------------------------------
  // stage 2: max of lows, median of mids, min of highs over the shifted window
  // --------------------------------------------------------------------------
  logic          p3_emit;
  logic          p3_inner;
  logic          p3_fend;
  logic [PB-1:0] p3_raw;
  logic [PB-1:0] p3_lo;
  logic [PB-1:0] p3_md;
  logic [PB-1:0] p3_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_emit <= 1'b0;
    end else begin
      p3_emit <= p2_emit;
    end
  end

  always_ff @(posedge clk) begin
    p3_inner <= p2_inner;
    p3_fend  <= p2_fend;
    p3_raw   <= p2_raw;
    p3_lo    <= acc_lo[WIN_COLS];
    p3_md    <= med3(cl_md[1], cl_md[2], cl_md[3]);
    p3_hi    <= acc_hi[WIN_COLS];
  end

  // --------------------------------------------------------------------------
  // stage 3: final median and border select into the result queue
  // --------------------------------------------------------------------------
  logic [PB-1:0]    val3;
  result_t          push_data;
  logic             pop;
  logic [CNT_W-1:0] q_count;
  logic [INF_W-1:0] inflight;

  assign val3      = p3_inner ? med3(p3_lo, p3_md, p3_hi) : p3_raw;
  assign push_data = '{pixel_out: PIX_W'(val3), frame_end: p3_fend};
  assign pop       = result_valid && !result_stall;

  medf_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (p3_emit),
    .push_data (push_data),
    .pop       (pop),
    .head      (result),
    .not_empty (result_valid),
    .count     (q_count)
  );

  // every result beat in flight holds a queue slot, so the queue never overflows
  assign inflight   = INF_W'(p1_emit) + INF_W'(p2_emit) + INF_W'(p3_emit) + INF_W'(q_count);
  assign item_stall = (inflight >= INF_W'(OUT_DEPTH));

endmodule

// ----- rtl/core/medf_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// read returns the old contents on a same-address write
// no dependencies
module medf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/medf_col_cell.sv -----
// one window column cell: holds a sorted pixel column and its center pixel
// shifts to its neighbor and extends the max-of-lows / min-of-highs chain
// no dependencies
module medf_col_cell #(
  parameter int PIX_BITS = 16
) (
  input  logic                clk,
  input  logic                shift,
  input  logic [PIX_BITS-1:0] lo_in,
  input  logic [PIX_BITS-1:0] md_in,
  input  logic [PIX_BITS-1:0] hi_in,
  input  logic [PIX_BITS-1:0] ctr_in,
  input  logic [PIX_BITS-1:0] lo_acc_in,
  input  logic [PIX_BITS-1:0] hi_acc_in,
  output logic [PIX_BITS-1:0] lo,
  output logic [PIX_BITS-1:0] md,
  output logic [PIX_BITS-1:0] hi,
  output logic [PIX_BITS-1:0] ctr,
  output logic [PIX_BITS-1:0] lo_acc,
  output logic [PIX_BITS-1:0] hi_acc
);

  always_ff @(posedge clk) begin
    if (shift) begin
      lo  <= lo_in;
      md  <= md_in;
      hi  <= hi_in;
      ctr <= ctr_in;
    end
  end

  assign lo_acc = (lo > lo_acc_in) ? lo : lo_acc_in;
  assign hi_acc = (hi < hi_acc_in) ? hi : hi_acc_in;

endmodule

// ----- rtl/core/medf_out_fifo.sv -----
// result queue between the filter pipeline and the output channel
// depends on medf_pkg for the result beat type
module medf_out_fifo #(
  parameter int DEPTH = medf_pkg::OUT_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  medf_pkg::result_t  push_data,
  input  logic               pop,
  output medf_pkg::result_t  head,
  output logic               not_empty,
  output logic [CNT_W-1:0]   count
);
  import medf_pkg::*;

  result_t          slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;

  assign wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

endmodule
